// ===== hw/rtl/csmv_pkg.sv =====
// ----------------------------------------------------------------------------
// csmv_pkg
// Shared types and constants of the sparse matrix-vector axpby unit.
// ----------------------------------------------------------------------------
package csmv_pkg;

  localparam int unsigned VEC_DEPTH_DEF = 1024;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_NONZERO = 2'd1;
  localparam logic [1:0] FUNC_LINE    = 2'd2;
  localparam logic [1:0] FUNC_READ    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = CFG_IDX_W'(2);

  localparam logic signed [VAL_W-1:0] ALPHA_RESET = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] BETA_RESET  = 32'sh0000_0000;

  typedef enum logic [2:0] {
    OP_LOAD_X,
    OP_NZ_ROW,
    OP_LINE_END,
    OP_LOAD_Y,
    OP_NZ_COL,
    OP_LINE_X,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
  } work_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] alpha;
    logic signed [VAL_W-1:0] beta;
    logic                    column_mode;
  } cfg_t;

endpackage

// ===== hw/rtl/csmv_if.sv =====
// ----------------------------------------------------------------------------
// csmv interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface csmv_item_if import csmv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output func, output index, output value, input ready);
  modport sink   (input valid, input func, input index, input value, output ready);
endinterface

interface csmv_result_if import csmv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic [IDX_W-1:0]        result_index;

  modport source (output valid, output result_value, output result_index, input ready);
  modport sink   (input valid, input result_value, input result_index, output ready);
endinterface

// ===== hw/rtl/csmv_ram.sv =====
// ----------------------------------------------------------------------------
// csmv_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module csmv_ram import csmv_pkg::*; #(
  parameter  int unsigned WIDTH = VAL_W,
  parameter  int unsigned DEPTH = VEC_DEPTH_DEF,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/csmv_front.sv =====
// ----------------------------------------------------------------------------
// csmv_front
// Accepts transactions, decodes the operation for the current layout,
// reduces the index to a store address and queues the work.
// ----------------------------------------------------------------------------
module csmv_front import csmv_pkg::*; #(
  parameter  int unsigned VEC_DEPTH = VEC_DEPTH_DEF,
  localparam int unsigned AW        = $clog2(VEC_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  csmv_item_if.sink     item,
  output logic          q_valid,
  output work_t         q_work,
  output logic [AW-1:0] q_addr,
  input  logic          q_pop
);

  localparam int unsigned RK    = 20;
  localparam int unsigned RECIP = (1 << RK) / VEC_DEPTH;
  localparam int unsigned PW    = IDX_W + RK;
  localparam int unsigned QDW   = IDX_W + 17;
  localparam int unsigned QPW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);

  logic [PW-1:0]    rprod;
  logic [IDX_W-1:0] quo;
  logic [QDW-1:0]   qd;
  logic [IDX_W-1:0] rem0;
  logic [IDX_W-1:0] rem1;
  logic [AW-1:0]    addr_in;
  work_t            work_in;

  work_t            qw [QUEUE_DEPTH];
  logic [AW-1:0]    qa [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [CW-1:0]    cnt;
  logic             push;

  // index modulo depth by reciprocal, quotient low by at most one
  always_comb begin
    rprod   = PW'(item.index) * PW'(RECIP);
    quo     = rprod[PW-1:RK];
    qd      = QDW'(quo) * QDW'(VEC_DEPTH);
    rem0    = IDX_W'(QDW'(item.index) - qd);
    rem1    = (QDW'(rem0) >= QDW'(VEC_DEPTH)) ? IDX_W'(QDW'(rem0) - QDW'(VEC_DEPTH)) : rem0;
    addr_in = AW'(rem1);
  end

  always_comb begin
    work_in.index = item.index;
    work_in.value = item.value;
    case (item.func)
      FUNC_LOAD:    work_in.op = cfg.column_mode ? OP_LOAD_Y : OP_LOAD_X;
      FUNC_NONZERO: work_in.op = cfg.column_mode ? OP_NZ_COL : OP_NZ_ROW;
      FUNC_LINE:    work_in.op = cfg.column_mode ? OP_LINE_X : OP_LINE_END;
      default:      work_in.op = OP_READ;
    endcase
  end

  assign item.ready = !rst && (cnt != CW'(QUEUE_DEPTH));
  assign push       = item.valid && item.ready;
  assign q_valid    = (cnt != '0);
  assign q_work     = qw[rd_ptr];
  assign q_addr     = qa[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qw[wr_ptr] <= work_in;
      qa[wr_ptr] <= addr_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// ===== hw/rtl/csmv_back.sv =====
// ----------------------------------------------------------------------------
// csmv_back
// Executes queued work: store access, shared 32x32 multiplier sequence,
// rounding, saturation and the result register.
// ----------------------------------------------------------------------------
module csmv_back import csmv_pkg::*; #(
  parameter  int unsigned VEC_DEPTH = VEC_DEPTH_DEF,
  localparam int unsigned AW        = $clog2(VEC_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          q_valid,
  input  work_t         q_work,
  input  logic [AW-1:0] q_addr,
  output logic          q_pop,
  csmv_result_if.source result
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_PMUL, S_ACC, S_PLO, S_PHI, S_ADD, S_RND, S_POST, S_EMIT
  } state_t;

  state_t                  state;
  op_t                     op;
  logic [AW-1:0]           addr;
  logic [IDX_W-1:0]        idx;
  logic signed [VAL_W-1:0] val;
  logic signed [VAL_W-1:0] rdat;
  logic signed [VAL_W-1:0] lm;
  logic signed [63:0]      row_sum;
  logic [31:0]             ga;
  logic [63:0]             mm;
  logic                    neg;
  logic                    sh48;
  logic                    stage;
  logic [63:0]             part;
  logic [94:0]             acc;
  logic signed [47:0]      srv;
  logic signed [47:0]      tsum;
  logic signed [VAL_W-1:0] pend;
  logic                    res_valid;
  logic signed [VAL_W-1:0] res_value;
  logic [IDX_W-1:0]        res_index;

  logic [63:0]             prod;
  logic [94:0]             rnd_sum;
  logic [46:0]             rnd_mag;
  logic [64:0]             p65;
  logic [64:0]             s65;
  logic signed [63:0]      row_sum_next;

  logic                    ram_we;
  logic [VAL_W-1:0]        ram_wdata;
  logic [VAL_W-1:0]        ram_rdata;

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? 32'd0 - x : x;
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  function automatic logic [31:0] sat32(input logic [48:0] x);
    if ((&x[48:31]) || !(|x[48:31])) begin
      return x[31:0];
    end
    return x[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  csmv_ram #(.WIDTH(VAL_W), .DEPTH(VEC_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (q_addr),
    .rdata (ram_rdata)
  );

  assign q_pop = (state == S_IDLE) && q_valid;

  assign result.valid        = res_valid;
  assign result.result_value = res_value;
  assign result.result_index = res_index;

  always_comb begin
    prod    = ga * ((state == S_PHI) ? mm[63:32] : mm[31:0]);
    rnd_sum = acc + (sh48 ? (95'(1) << 47) : (95'(1) << 15));
    rnd_mag = sh48 ? 47'(rnd_sum >> 48) : 47'(rnd_sum >> 16);
    p65     = neg ? 65'd0 - {1'b0, part} : {1'b0, part};
    s65     = {row_sum[63], row_sum} + p65;
    if (s65[64] != s65[63]) begin
      row_sum_next = s65[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      row_sum_next = s65[63:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = val;
    if (state == S_LOAD && op == OP_LOAD_X) begin
      ram_we = 1'b1;
    end else if (state == S_POST && op == OP_LOAD_Y) begin
      ram_we    = 1'b1;
      ram_wdata = sat32({srv[47], srv});
    end else if (state == S_POST && op == OP_NZ_COL) begin
      ram_we    = 1'b1;
      ram_wdata = sat32({{17{rdat[31]}}, rdat} + {srv[47], srv});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      row_sum   <= '0;
      lm        <= '0;
    end else begin
      if (res_valid && result.ready && state != S_EMIT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            op    <= q_work.op;
            idx   <= q_work.index;
            val   <= q_work.value;
            addr  <= q_addr;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          rdat <= ram_rdata;
          case (op)
            OP_LOAD_X: state <= S_IDLE;
            OP_LINE_X: begin
              lm    <= val;
              state <= S_IDLE;
            end
            OP_READ: begin
              pend  <= ram_rdata;
              state <= S_EMIT;
            end
            OP_NZ_ROW: begin
              ga    <= abs32(val);
              mm    <= {32'd0, abs32(ram_rdata)};
              neg   <= val[31] ^ ram_rdata[31];
              state <= S_PMUL;
            end
            OP_NZ_COL: begin
              ga    <= abs32(val);
              mm    <= {32'd0, abs32(lm)};
              neg   <= val[31] ^ lm[31];
              state <= S_PMUL;
            end
            OP_LOAD_Y, OP_LINE_END: begin
              ga    <= abs32(cfg.beta);
              mm    <= {32'd0, abs32(val)};
              neg   <= cfg.beta[31] ^ val[31];
              sh48  <= 1'b0;
              stage <= 1'b0;
              state <= S_PLO;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_PMUL: begin
          if (op == OP_NZ_ROW) begin
            part  <= prod;
            state <= S_ACC;
          end else begin
            mm    <= prod;
            ga    <= abs32(cfg.alpha);
            neg   <= neg ^ cfg.alpha[31];
            sh48  <= 1'b1;
            state <= S_PLO;
          end
        end
        S_ACC: begin
          row_sum <= row_sum_next;
          state   <= S_IDLE;
        end
        S_PLO: begin
          part  <= prod;
          state <= S_PHI;
        end
        S_PHI: begin
          acc   <= {31'd0, part};
          part  <= prod;
          state <= S_ADD;
        end
        S_ADD: begin
          acc   <= acc + 95'({part, 32'd0});
          state <= S_RND;
        end
        S_RND: begin
          srv   <= neg ? 48'sd0 - 48'(rnd_mag) : 48'(rnd_mag);
          state <= S_POST;
        end
        S_POST: begin
          case (op)
            OP_LINE_END: begin
              if (!stage) begin
                tsum  <= srv;
                stage <= 1'b1;
                ga    <= abs32(cfg.alpha);
                mm    <= abs64(row_sum);
                neg   <= cfg.alpha[31] ^ row_sum[63];
                sh48  <= 1'b1;
                state <= S_PLO;
              end else begin
                pend    <= sat32({tsum[47], tsum} + {srv[47], srv});
                row_sum <= '0;
                state   <= S_EMIT;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_EMIT: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_value <= pend;
            res_index <= idx;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_line_clears_sum: assert property (@(posedge clk) disable iff (rst)
    (state == S_POST && op == OP_LINE_END && stage) |=> row_sum == '0)
    else $error("row sum not cleared after line end");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RND |-> rnd_mag <= (47'(1) << 46))
    else $error("rounded magnitude out of range");

  a_single_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !q_pop)
    else $error("second pop while a transaction is in flight");

endmodule

// ===== hw/rtl/csr_sparse_matvec_axpby_unit.sv =====
// ----------------------------------------------------------------------------
// csr_sparse_matvec_axpby_unit
// y = alpha*A*x + beta*y over a stream of sparse nonzeros, Q16.16 operands,
// Q32.32 sums, saturated 32-bit results, row or column compressed layout.
//
//   channel  dir  handshake      payload
//   item     in   valid/ready    func, index, value
//   result   out  valid/ready    result_value, result_index
//   cfg      in   cfg_we         cfg_index, cfg_wdata
//
// the back end executes one transaction at a time and pops the next only when idle
// a row line end scales beta*value and then alpha*row sum before it emits
// the shared 32x32 multiplier is used twice per scaled product, for its low and high halves
// a 2-entry queue decouples acceptance from execution
// result waits in an output register; a stalled sink holds the back end at emit
// synchronous reset clears control state; store contents are undefined until written
// ----------------------------------------------------------------------------
module csr_sparse_matvec_axpby_unit import csmv_pkg::*; #(
  parameter int unsigned VEC_DEPTH = VEC_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  csmv_item_if.sink            item,
  csmv_result_if.source        result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_wdata
);

  localparam int unsigned AW = $clog2(VEC_DEPTH);

  cfg_t          cfg;
  logic          q_valid;
  work_t         q_work;
  logic [AW-1:0] q_addr;
  logic          q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha       <= ALPHA_RESET;
      cfg.beta        <= BETA_RESET;
      cfg.column_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA: cfg.alpha       <= cfg_wdata;
        CFG_BETA:  cfg.beta        <= cfg_wdata;
        CFG_MODE:  cfg.column_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  csmv_front #(.VEC_DEPTH(VEC_DEPTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (item),
    .q_valid (q_valid),
    .q_work  (q_work),
    .q_addr  (q_addr),
    .q_pop   (q_pop)
  );

  csmv_back #(.VEC_DEPTH(VEC_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_work  (q_work),
    .q_addr  (q_addr),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

// ===== tb/sv/tb_csr_sparse_matvec_axpby_unit.sv =====
// ----------------------------------------------------------------------------
// tb_csr_sparse_matvec_axpby_unit
// Self-checking bench for the sparse matrix-vector axpby unit. A directed
// table covers store extremes, empty rows and sum saturation. It is followed
// by random row and column phases under several alpha/beta settings, with
// random idling on both sides and one long result stall. Each result is
// compared with an in-bench Q16.16 predictor or a value from the table.
// ----------------------------------------------------------------------------
module tb_csr_sparse_matvec_axpby_unit;
  import csmv_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 185;
  localparam int DRAIN_WAIT  = 50;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0]        idx;
  } y_entry_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    bit               typed;
    logic [VAL_W-1:0] want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ALPHA;
  logic [VAL_W-1:0] cfg_wdata = '0;

  csmv_item_if   item_ch ();
  csmv_result_if res_ch ();

  csr_sparse_matvec_axpby_unit dut (
    .clk(clk), .rst(rst), .item(item_ch), .result(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [VAL_W-1:0] p_alpha, p_beta, p_line_x;
  logic                    p_col;
  logic signed [VAL_W-1:0] p_store [0:VEC_DEPTH_DEF-1];
  logic signed [63:0]      p_row_sum;
  bit                      was_written [0:VEC_DEPTH_DEF-1];
  int                      written_idx [$];

  y_entry_t expected_y [$];
  int  err_count = 0;
  int  cycles = 0;
  int  tx_idle = 0;
  int  rx_idle = 0;
  bit  hold_req = 0;

  function automatic logic signed [63:0] scale_rnd(logic signed [31:0] g,
                                                   logic signed [63:0] m, int s);
    logic [63:0]  gm, mm;
    logic [127:0] full;
    bit           neg;
    neg = g[31] ^ m[63];
    gm = g[31] ? -{{32{g[31]}}, g} : {32'b0, g};
    mm = m[63] ? -m : m;
    full = ({64'b0, gm} * {64'b0, mm} + (128'd1 << (s - 1))) >> s;
    if (full > (128'd1 << 62)) full = 128'd1 << 62;
    return neg ? -$signed(full[63:0]) : $signed(full[63:0]);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic bit predict_axpby(logic [1:0] func, logic [IDX_W-1:0] idx,
                                       logic signed [31:0] val, output y_entry_t y);
    logic signed [64:0] sum;
    logic signed [63:0] t;
    y.idx = idx;
    y.val = '0;
    if (func == FUNC_READ) begin
      y.val = p_store[idx];
      return 1;
    end
    if (!p_col) begin
      case (func)
        FUNC_LOAD: p_store[idx] = val;
        FUNC_NONZERO: begin
          t = 64'(val) * 64'(p_store[idx]);
          sum = $signed({p_row_sum[63], p_row_sum}) + $signed({t[63], t});
          if (sum[64] != sum[63]) p_row_sum = sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
          else p_row_sum = sum[63:0];
        end
        default: begin
          y.val = sat32(scale_rnd(p_alpha, p_row_sum, 48) + scale_rnd(p_beta, 64'(val), 16));
          p_row_sum = '0;
          return 1;
        end
      endcase
    end else begin
      case (func)
        FUNC_LOAD: p_store[idx] = sat32(scale_rnd(p_beta, 64'(val), 16));
        FUNC_NONZERO: begin
          t = scale_rnd(p_alpha, 64'(val) * 64'(p_line_x), 48);
          p_store[idx] = sat32(64'(p_store[idx]) + t);
        end
        default: p_line_x = val;
      endcase
    end
    return 0;
  endfunction

  task automatic send_item(logic [1:0] func, logic [IDX_W-1:0] idx, logic [31:0] val,
                           bit typed = 0, logic [31:0] want = '0);
    y_entry_t y;
    while ($urandom_range(99) < tx_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.func  <= func;
    item_ch.index <= idx;
    item_ch.value <= val;
    @(negedge clk);
    while (!item_ch.ready) @(negedge clk);
    @(posedge clk);
    if (func == FUNC_LOAD && !was_written[idx]) begin
      was_written[idx] = 1;
      written_idx.insert(written_idx.size(), int'(idx));
    end
    if (predict_axpby(func, idx, val, y)) begin
      if (typed) y.val = want;
      expected_y.insert(expected_y.size(), y);
    end
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] ridx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= ridx;
    cfg_wdata <= data;
    @(posedge clk);
    case (ridx)
      CFG_ALPHA: p_alpha = data;
      CFG_BETA:  p_beta = data;
      default:   p_col = data[0];
    endcase
  endtask

  task automatic set_phase(logic [31:0] a, logic [31:0] b, bit col);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_y.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    write_cfg(CFG_ALPHA, a);
    write_cfg(CFG_BETA, b);
    write_cfg(CFG_MODE, {31'b0, col});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(3))
      0: return $urandom_range(393216) - 196608;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_written();
    return IDX_W'(written_idx[$urandom_range(written_idx.size() - 1)]);
  endfunction

  // result side
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  always @(negedge clk) begin
    y_entry_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_y.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result idx=%0d val=%h", res_ch.result_index, res_ch.result_value);
      end else begin
        e = expected_y.pop_front();
        if (e.val !== res_ch.result_value || e.idx !== res_ch.result_index) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp idx=%0d val=%h, got idx=%0d val=%h",
                     e.idx, e.val, res_ch.result_index, res_ch.result_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  dir_row_t dir_tab [0:20] = '{
    '{FUNC_LOAD,    10'd0,    32'h7fffffff, 1'b0, 32'h0},
    '{FUNC_LOAD,    10'd1023, 32'h80000000, 1'b0, 32'h0},
    '{FUNC_LOAD,    10'd5,    32'h00010000, 1'b0, 32'h0},
    '{FUNC_LOAD,    10'd6,    32'hffff0000, 1'b0, 32'h0},
    '{FUNC_READ,    10'd0,    32'h0,        1'b1, 32'h7fffffff},
    '{FUNC_READ,    10'd1023, 32'h0,        1'b1, 32'h80000000},
    '{FUNC_LINE,    10'd3,    32'h12345678, 1'b1, 32'h0},
    '{FUNC_NONZERO, 10'd5,    32'h00020000, 1'b0, 32'h0},
    '{FUNC_NONZERO, 10'd6,    32'h00008000, 1'b0, 32'h0},
    '{FUNC_LINE,    10'd9,    32'h0,        1'b0, 32'h0},
    '{FUNC_NONZERO, 10'd0,    32'h7fffffff, 1'b0, 32'h0},
    '{FUNC_NONZERO, 10'd0,    32'h7fffffff, 1'b0, 32'h0},
    '{FUNC_NONZERO, 10'd0,    32'h7fffffff, 1'b0, 32'h0},
    '{FUNC_NONZERO, 10'd0,    32'h7fffffff, 1'b0, 32'h0},
    '{FUNC_LINE,    10'd1,    32'hffffffff, 1'b1, 32'h7fffffff},
    '{FUNC_NONZERO, 10'd1023, 32'h7fffffff, 1'b0, 32'h0},
    '{FUNC_NONZERO, 10'd1023, 32'h7fffffff, 1'b0, 32'h0},
    '{FUNC_NONZERO, 10'd1023, 32'h7fffffff, 1'b0, 32'h0},
    '{FUNC_NONZERO, 10'd1023, 32'h7fffffff, 1'b0, 32'h0},
    '{FUNC_LINE,    10'd2,    32'h0,        1'b1, 32'h80000000},
    '{FUNC_READ,    10'd5,    32'h0,        1'b1, 32'h00010000}
  };

  logic [31:0] ph_alpha [0:5] = '{32'h00010000, 32'h7fffffff, 32'h0, 32'h80000000,
                                  32'h0, 32'h0};
  logic [31:0] ph_beta  [0:5] = '{32'h0, 32'h80000000, 32'h0, 32'h7fffffff, 32'h0, 32'h0};
  bit          ph_col   [0:5] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  initial begin
    int n, k, r;
    logic [31:0] a, b;
    item_ch.valid = 1'b0;
    item_ch.func  = FUNC_LOAD;
    item_ch.index = '0;
    item_ch.value = '0;
    p_alpha = ALPHA_RESET;
    p_beta = BETA_RESET;
    p_col = 1'b0;
    p_row_sum = '0;
    p_line_x = '0;
    foreach (p_store[i]) begin
      p_store[i] = '0;
      was_written[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle = 37;
    rx_idle = 53;
    foreach (dir_tab[i])
      send_item(dir_tab[i].func, dir_tab[i].idx, dir_tab[i].val,
                dir_tab[i].typed, dir_tab[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      a = ph_alpha[ph];
      b = ph_beta[ph];
      if (ph == 2 || ph == 4) begin
        a = $urandom_range(3) == 0 ? $urandom : $urandom_range(262144) - 131072;
        b = $urandom_range(3) == 0 ? $urandom : $urandom_range(262144) - 131072;
      end
      set_phase(a, b, ph_col[ph]);
      tx_idle = (ph < 2) ? 37 : (ph < 4) ? 53 : 0;
      rx_idle = (ph < 2) ? 53 : (ph < 4) ? 37 : 0;
      if (ph == 4) hold_req = 1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 12) begin
          send_item(FUNC_LOAD, IDX_W'($urandom_range(1023)), rand_val());
          n++;
        end else if (r < 22) begin
          send_item(FUNC_READ, pick_written(), $urandom);
          n++;
        end else begin
          k = $urandom_range(6);
          if (ph_col[ph]) send_item(FUNC_LINE, IDX_W'($urandom_range(1023)), rand_val());
          repeat (k) send_item(FUNC_NONZERO, pick_written(), rand_val());
          if (!ph_col[ph]) send_item(FUNC_LINE, IDX_W'($urandom_range(1023)), rand_val());
          n += k + 1;
        end
      end
    end

    item_ch.valid <= 1'b0;
    while (expected_y.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
